// ----- rtl/core/ffud_pkg.sv -----
// Shared types and character constants for the form field extractor.
package ffud_pkg;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       last;
  } query_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
  } result_item_t;

  // One queue entry: up to three results produced by one input byte.
  typedef struct packed {
    logic [1:0]               cnt;
    result_item_t [2:0]       slot;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_FINISHED
  } phase_t;

  localparam logic [1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [1:0] REG_KEY_HIGH   = 2'd2;

  localparam int KEY_BYTES_STORED = 16;

  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CASE_BIT   = 8'h20;
  localparam logic [7:0] HIGH_BYTE  = 8'h80;
  localparam logic [7:0] DIGIT_TEN  = 8'd10;

endpackage

// ----- rtl/core/ffud_front.sv -----
// Front end: key registers, field matching and percent decoding into queue commands.
module ffud_front #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  input  logic                  accept,
  input  ffud_pkg::query_item_t item,
  output logic                  push,
  output ffud_pkg::cmd_t        cmd
);

  logic [4:0]  key_length;
  logic [63:0] key_low;
  logic [63:0] key_high;

  ffud_pkg::phase_t phase, phase_next;
  logic [4:0] match_position, match_position_next;
  logic [1:0] held_count, held_count_next;
  logic [7:0] held_byte, held_byte_next;

  logic [ffud_pkg::KEY_BYTES_STORED-1:0][7:0] key_arr;
  logic [4:0]       klen;
  logic [7:0]       b;
  logic [7:0]       hi_digit;
  logic [7:0]       lo_digit;
  logic [1:0]       cnt;
  ffud_pkg::result_item_t [2:0] slot;

  function automatic ffud_pkg::result_item_t make_byte(input logic [7:0] v);
    ffud_pkg::result_item_t r;
    r.value_byte = v;
    r.byte_valid = 1'b1;
    r.done_res   = 1'b0;
    r.found      = 1'b0;
    return r;
  endfunction

  function automatic ffud_pkg::result_item_t make_done(input logic f);
    ffud_pkg::result_item_t r;
    r.value_byte = 8'd0;
    r.byte_valid = 1'b0;
    r.done_res   = 1'b1;
    r.found      = f;
    return r;
  endfunction

  // Signed-char view: bytes at or above 0x80 take the decimal path.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if (c <= ffud_pkg::CH_NINE || c >= ffud_pkg::HIGH_BYTE) begin
      d = c - ffud_pkg::CH_ZERO;
    end else begin
      d = (c | ffud_pkg::CASE_BIT) - ffud_pkg::CH_A_LOWER + ffud_pkg::DIGIT_TEN;
    end
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_low    <= '0;
      key_high   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ffud_pkg::REG_KEY_LENGTH: key_length <= cfg_data[4:0];
        ffud_pkg::REG_KEY_LOW:    key_low    <= cfg_data;
        ffud_pkg::REG_KEY_HIGH:   key_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign key_arr  = {key_high, key_low};
  assign klen     = (key_length > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : key_length;
  assign b        = item.query_byte;
  assign hi_digit = digit_value(held_byte);
  assign lo_digit = digit_value(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ffud_pkg::PH_MATCH;
      match_position <= '0;
      held_count     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      match_position <= match_position_next;
      held_count     <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= held_byte_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    held_count_next     = held_count;
    held_byte_next      = held_byte;
    slot                = '0;
    cnt                 = 2'd0;

    unique case (phase)
      ffud_pkg::PH_MATCH: begin
        if (match_position < klen) begin
          if (b == key_arr[match_position[3:0]]) begin
            match_position_next = match_position + 5'd1;
          end else if (b == ffud_pkg::CH_AMP) begin
            match_position_next = '0;
          end else begin
            phase_next = ffud_pkg::PH_SKIP;
          end
        end else if (b == ffud_pkg::CH_EQUALS) begin
          phase_next      = ffud_pkg::PH_VALUE;
          held_count_next = 2'd0;
        end else if (b == ffud_pkg::CH_AMP) begin
          match_position_next = '0;
        end else begin
          phase_next = ffud_pkg::PH_SKIP;
        end
      end
      ffud_pkg::PH_SKIP: begin
        if (b == ffud_pkg::CH_AMP) begin
          phase_next          = ffud_pkg::PH_MATCH;
          match_position_next = '0;
        end
      end
      ffud_pkg::PH_VALUE: begin
        if (held_count == 2'd0) begin
          if (b == ffud_pkg::CH_AMP) begin
            slot[0]    = make_done(1'b1);
            cnt        = 2'd1;
            phase_next = ffud_pkg::PH_FINISHED;
          end else if (b == ffud_pkg::CH_PLUS) begin
            slot[0] = make_byte(ffud_pkg::CH_SPACE);
            cnt     = 2'd1;
          end else if (b == ffud_pkg::CH_PERCENT) begin
            held_count_next = 2'd1;
          end else begin
            slot[0] = make_byte(b);
            cnt     = 2'd1;
          end
        end else if (held_count == 2'd1) begin
          held_byte_next  = b;
          held_count_next = 2'd2;
        end else begin
          // escape: high digit keeps only its low nibble, low digit ORs in whole
          slot[0] = make_byte({hi_digit[3:0], 4'd0} | lo_digit);
          cnt     = 2'd1;
          held_count_next = 2'd0;
        end
      end
      ffud_pkg::PH_FINISHED: ;
      default: ;
    endcase

    if (item.last) begin
      if (phase_next == ffud_pkg::PH_VALUE) begin
        // short escape at end of string is flushed as text (a held '+' as space, a held '&' dropped)
        if (held_count_next != 2'd0) begin
          slot[cnt] = make_byte(ffud_pkg::CH_PERCENT);
          cnt       = cnt + 2'd1;
        end
        if (held_count_next == 2'd2 && held_byte_next != ffud_pkg::CH_AMP) begin
          slot[cnt] = make_byte((held_byte_next == ffud_pkg::CH_PLUS) ?
                                ffud_pkg::CH_SPACE : held_byte_next);
          cnt       = cnt + 2'd1;
        end
        slot[cnt] = make_done(1'b1);
        cnt       = cnt + 2'd1;
      end else if (phase_next != ffud_pkg::PH_FINISHED) begin
        slot[cnt] = make_done(1'b0);
        cnt       = cnt + 2'd1;
      end
      phase_next          = ffud_pkg::PH_MATCH;
      match_position_next = '0;
      held_count_next     = 2'd0;
    end
  end

  assign cmd.cnt  = cnt;
  assign cmd.slot = slot;
  assign push     = accept && (cnt != 2'd0);

`ifndef ASSERT_OFF
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && item.last) |=> (phase == ffud_pkg::PH_MATCH && held_count == 2'd0
                               && match_position == 5'd0))
    else $error("state not restarted after final byte");
`endif

endmodule

// ----- rtl/core/ffud_queue.sv -----
// Small register FIFO between the front end and the result sequencer.
module ffud_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/core/ffud_back.sv -----
// Back end: walks the results of each queued command into the output register.
module ffud_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ffud_pkg::cmd_t         head,
  input  logic                   empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ffud_pkg::result_item_t out_item
);

  logic [1:0] idx;
  logic       load;
  logic       take;

  assign load = !out_valid || out_ready;
  assign take = load && !empty;
  assign pop  = take && (idx == head.cnt - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        idx       <= pop ? 2'd0 : idx + 2'd1;
      end else if (load) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= head.slot[idx];
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (head.cnt != 2'd0 && idx < head.cnt))
    else $error("result index past command count");
`endif

endmodule

// ----- rtl/core/form_field_extract_url_decode.sv -----
// Form field extractor with URL percent decoding: top level.
// Input channel (in_valid/in_ready/in_item): one query byte per transfer, with
// last set on the final byte of a string. Output channel (out_valid/out_ready/
// out_item): decoded value bytes (byte_valid) and one done item per string
// (done_res, found). Configuration: cfg_write with cfg_index 0 writes the key
// length, 1 key bytes 0..7, 2 key bytes 8..15; write only while idle.
// Throughput: one input byte per cycle while results keep up. A byte yields
// zero to three results; the output register sends one result per cycle
// while out_ready is high, and each result takes its own output transfer.
// Path: an accepted byte's command is written into the queue register; its
// first result is then loaded from the queue head into the output register,
// which presents it on the output channel while out_valid is high.
// When the receiver stalls, the command queue (QUEUE_DEPTH entries) keeps
// filling and in_ready drops only when it is full; bytes with no results
// never occupy the queue.
// Reset (rst, synchronous): key registers clear to zero, matching restarts
// at a field start, queue and output register empty.
module form_field_extract_url_decode #(
  parameter int MAX_KEY_BYTES = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ffud_pkg::query_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ffud_pkg::result_item_t out_item
);

  localparam int CMD_W = $bits(ffud_pkg::cmd_t);

  logic           accept;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  ffud_pkg::cmd_t cmd;
  ffud_pkg::cmd_t head_cmd;
  logic [CMD_W-1:0] head_bits;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign head_cmd = head_bits;

  ffud_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (in_item),
    .push     (push),
    .cmd      (cmd)
  );

  ffud_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(cmd),
    .full     (full),
    .pop      (pop),
    .head     (head_bits),
    .empty    (empty)
  );

  ffud_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head_cmd),
    .empty    (empty),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule
